@@ src/countdown_seven_segment_timer_unit_defines.svh @@
// Assertion macros shared by the countdown timer RTL.
`ifndef COUNTDOWN_SEVEN_SEGMENT_TIMER_UNIT_DEFINES_SVH
`define COUNTDOWN_SEVEN_SEGMENT_TIMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cond holds at every clock edge out of reset.
`define CDST_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define CDST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CDST_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define CDST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/cdst_pkg.sv @@
// Types, command codes and segment table for the countdown timer.
package cdst_pkg;

    // Command codes carried in the op field
    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_START = 3'd2,
        OP_STOP  = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    // Longest countdown that a load accepts, in seconds
    localparam logic [6:0] MAX_SECONDS = 7'd64;

    // Segment patterns for decimal digits, bit 0 is segment a
    localparam logic [6:0] SEG_TABLE [10] = '{
        7'd63, 7'd6, 7'd91, 7'd79, 7'd102, 7'd109, 7'd125, 7'd7, 7'd127, 7'd111
    };

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] start_seconds;
    } t_cmd;

    typedef struct packed {
        logic [6:0]  segments;
        logic        digit_select;
        logic        countdown_done;
        logic [31:0] tick_total;
        logic [31:0] run_ticks;
    } t_res;

    // Look up the segment pattern of one decimal digit
    function automatic logic [6:0] seg_for(input logic [3:0] digit);
        logic [6:0] pat;
        pat = 7'd0;
        if (digit < 4'd10) begin
            pat = SEG_TABLE[digit];
        end
        return pat;
    endfunction

endpackage

@@ src/countdown_seven_segment_timer_unit.sv @@
// Countdown timer with a two-digit multiplexed seven-segment display. Each
// request is one command (tick, load seconds, start, stop, clear) and yields
// exactly one result with the latched segment pattern, the digit select, the
// done flag and both tick counts. A new request is taken every clock cycle:
// the whole update is one pass of logic from the state registers into the
// result register, and the result register lets a new request in while the
// previous result is taken in the same cycle. The remaining time is kept as
// whole seconds plus a sub-second tick count, so the displayed digits need
// no divider. The request side stalls only while a result waits unaccepted.
`include "countdown_seven_segment_timer_unit_defines.svh"

module countdown_seven_segment_timer_unit #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cdst_pkg::t_cmd i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output cdst_pkg::t_res o_out_data
);

    localparam int SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

    // State: remaining time is r_secs * TICKS_PER_SECOND + r_sub
    logic [31:0]      r_tick_total, n_tick_total;
    logic [31:0]      r_run_ticks,  n_run_ticks;
    logic [6:0]       r_secs,       n_secs;
    logic [SUB_W-1:0] r_sub,        n_sub;
    logic             r_running,    n_running;
    logic [1:0]       r_phase,      n_phase;
    logic [6:0]       r_seg,        n_seg;

    logic             r_out_valid;
    cdst_pkg::t_res   r_out_data;

    logic             in_fire;
    logic             n_done;
    logic [6:0]       clamp_secs;
    logic [6:0]       shown;
    logic [17:0]      div_prod;
    logic [3:0]       tens_digit;
    logic [6:0]       ones_wide;
    logic [3:0]       ones_digit;
    logic             tens_lit;
    logic [6:0]       tick_seg;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    // Clamp the load value to the longest countdown
    assign clamp_secs = (i_in_data.start_seconds > {1'b0, cdst_pkg::MAX_SECONDS})
                        ? cdst_pkg::MAX_SECONDS : i_in_data.start_seconds[6:0];

    // Apply one command to the counters
    always_comb begin
        n_tick_total = r_tick_total;
        n_run_ticks  = r_run_ticks;
        n_secs       = r_secs;
        n_sub        = r_sub;
        n_running    = r_running;
        n_phase      = r_phase;
        case (i_in_data.op)
            cdst_pkg::OP_TICK: begin
                n_tick_total = r_tick_total + 32'd1;
                n_phase      = r_phase + 2'd1;
                if (r_running) begin
                    n_run_ticks = r_run_ticks + 32'd1;
                    if (r_sub != '0) begin
                        n_sub = r_sub - SUB_W'(1);
                    end else if (r_secs != 7'd0) begin
                        n_secs = r_secs - 7'd1;
                        n_sub  = SUB_LAST;
                    end
                end
            end
            cdst_pkg::OP_LOAD: begin
                n_secs = clamp_secs;
                n_sub  = '0;
            end
            cdst_pkg::OP_START: n_running = 1'b1;
            cdst_pkg::OP_STOP:  n_running = 1'b0;
            cdst_pkg::OP_CLEAR: begin
                n_secs = 7'd0;
                n_sub  = '0;
            end
            default: ;
        endcase
    end

    assign n_done = (n_secs == 7'd0) && (n_sub == '0);

    // Split whole seconds left plus one into decimal digits (v / 10 by reciprocal)
    assign shown      = n_secs + 7'd1;
    assign div_prod   = 18'(shown) * 18'd205;
    assign tens_digit = div_prod[14:11];
    assign ones_wide  = shown - 7'(7'(tens_digit) * 7'd10);
    assign ones_digit = ones_wide[3:0];

    // Tens digit lights only above nine full seconds left
    assign tens_lit = (n_secs > 7'd9) || ((n_secs == 7'd9) && (n_sub != '0));

    // Pick the pattern for the digit that the new phase selects
    always_comb begin
        if (n_done) begin
            tick_seg = 7'd0;
        end else if (!n_phase[1]) begin
            tick_seg = cdst_pkg::seg_for(ones_digit);
        end else if (tens_lit) begin
            tick_seg = cdst_pkg::seg_for(tens_digit);
        end else begin
            tick_seg = 7'd0;
        end
    end

    // Latch the display only on a tick
    assign n_seg = (i_in_data.op == cdst_pkg::OP_TICK) ? tick_seg : r_seg;

    // Advance state on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_total <= '0;
            r_run_ticks  <= '0;
            r_secs       <= '0;
            r_sub        <= '0;
            r_running    <= 1'b0;
            r_phase      <= '0;
            r_seg        <= '0;
        end else if (in_fire) begin
            r_tick_total <= n_tick_total;
            r_run_ticks  <= n_run_ticks;
            r_secs       <= n_secs;
            r_sub        <= n_sub;
            r_running    <= n_running;
            r_phase      <= n_phase;
            r_seg        <= n_seg;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data.segments       <= n_seg;
            r_out_data.digit_select   <= n_phase[1];
            r_out_data.countdown_done <= n_done;
            r_out_data.tick_total     <= n_tick_total;
            r_out_data.run_ticks      <= n_run_ticks;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `CDST_ASSERT_ALWAYS(a_sub_range, i_clk, i_rst_n, r_sub <= SUB_LAST, "sub-second count out of range")
    `CDST_ASSERT_ALWAYS(a_secs_range, i_clk, i_rst_n, r_secs <= cdst_pkg::MAX_SECONDS, "seconds above clamp")
    `CDST_ASSERT_ALWAYS(a_stall_only_full, i_clk, i_rst_n, o_in_ready || r_out_valid, "stall without a pending result")
    `CDST_ASSERT_NEXT(a_fire_valid, i_clk, i_rst_n, in_fire, r_out_valid, "accepted request gave no result")
    `CDST_ASSERT_NEXT(a_tick_count, i_clk, i_rst_n, in_fire && (i_in_data.op == cdst_pkg::OP_TICK), r_tick_total == $past(r_tick_total) + 32'd1, "tick count did not advance")
    `CDST_ASSERT_NEXT(a_load_sub, i_clk, i_rst_n, in_fire && (i_in_data.op == cdst_pkg::OP_LOAD), r_sub == '0, "load left a sub-second remainder")

endmodule

@@ verif/countdown_seven_segment_timer_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the countdown seven-segment timer unit.
module countdown_seven_segment_timer_unit_test;
    import cdst_pkg::*;

    localparam int TICKS_PER_SEC = 1000;
    localparam int NUM_OP_CODES = 8;
    localparam int RANDOM_REQUESTS = 600;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    // Segment patterns for digits 0 to 9, segment a in bit 0
    localparam logic [6:0] DIGIT_SEGS [10] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_cmd i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_res o_out_data;

    // Timer state as the testbench expects it
    logic [31:0] tick_total_q = '0;
    logic [31:0] run_ticks_q = '0;
    logic [15:0] remain_ms_q = '0;
    bit          running_q = 1'b0;
    logic [1:0]  mux_phase_q = '0;
    logic [6:0]  latch_q = '0;

    t_cmd pending_cmds[$];
    t_res expected_results[$];
    int   live_count = 0;
    int   failures = 0;
    int   idle_cycles = 0;
    int   send_gap = 0;
    int   ready_hold = 0;
    bit   steady = 1'b0;
    bit   cmd_taken = 1'b0;

    countdown_seven_segment_timer_unit #(
        .TICKS_PER_SECOND(TICKS_PER_SEC)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Pattern for one digit of the whole seconds left plus one, blank at zero
    function automatic logic [6:0] digit_pattern(input logic [15:0] remain,
                                                 input logic tens);
        int unsigned shown;
        if (remain == 16'd0) return 7'd0;
        shown = remain + TICKS_PER_SEC;
        if (!tens) return DIGIT_SEGS[(shown / TICKS_PER_SEC) % 10];
        if (shown > 10 * TICKS_PER_SEC) return DIGIT_SEGS[(shown / (10 * TICKS_PER_SEC)) % 10];
        return 7'd0;
    endfunction

    // Advance the expected timer state by one request and report the result
    function automatic t_res apply_command(input t_cmd cmd);
        t_res res;
        int unsigned secs;
        case (cmd.op)
            OP_TICK: begin
                tick_total_q = tick_total_q + 32'd1;
                if (running_q) begin
                    run_ticks_q = run_ticks_q + 32'd1;
                    if (remain_ms_q != 16'd0) remain_ms_q = remain_ms_q - 16'd1;
                end
                mux_phase_q = mux_phase_q + 2'd1;
                latch_q = digit_pattern(remain_ms_q, mux_phase_q[1]);
            end
            OP_LOAD: begin
                secs = (cmd.start_seconds > MAX_SECONDS) ? MAX_SECONDS : cmd.start_seconds;
                remain_ms_q = 16'(secs * TICKS_PER_SEC);
            end
            OP_START: running_q = 1'b1;
            OP_STOP:  running_q = 1'b0;
            OP_CLEAR: remain_ms_q = 16'd0;
            default: ;
        endcase
        res.segments       = latch_q;
        res.digit_select   = mux_phase_q[1];
        res.countdown_done = (remain_ms_q == 16'd0);
        res.tick_total     = tick_total_q;
        res.run_ticks      = run_ticks_q;
        return res;
    endfunction

    // Pick an idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if ($urandom_range(0, 199) == 0) steady = !steady;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_cmd(input logic [2:0] op, input logic [7:0] secs);
        t_cmd cmd;
        cmd.op = op;
        cmd.start_seconds = secs;
        pending_cmds.push_back(cmd);
        if (op <= OP_CLEAR) live_count++;
    endtask

    task automatic add_ticks(input int count);
        repeat (count) add_cmd(OP_TICK, 8'($urandom));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Present requests at the falling edge; hold each until it is taken
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !cmd_taken)) begin
            if (i_in_valid) send_gap = pick_gap();
            if (send_gap == 0 && pending_cmds.size() != 0) begin
                i_in_data  <= pending_cmds.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold--;
        end else begin
            i_out_ready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    // Predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            idle_cycles++;
            if (i_in_valid && o_in_ready) begin
                cmd_taken = 1'b1;
                idle_cycles = 0;
                expected_results.push_back(apply_command(i_in_data));
            end
            if (o_out_valid && i_out_ready) begin
                idle_cycles = 0;
                if (expected_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    failures++;
                end else begin
                    t_res want;
                    want = expected_results.pop_front();
                    check_field("segments", 32'(want.segments), 32'(o_out_data.segments));
                    check_field("digit_select", 32'(want.digit_select),
                                32'(o_out_data.digit_select));
                    check_field("countdown_done", 32'(want.countdown_done),
                                32'(o_out_data.countdown_done));
                    check_field("tick_total", want.tick_total, o_out_data.tick_total);
                    check_field("run_ticks", want.run_ticks, o_out_data.run_ticks);
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int roll;
        logic [7:0] secs;

        // Directed: reset display, unused codes, clamping, repeated start/stop,
        // tens digit blank at exactly nine seconds and on at exactly ten, clear
        add_ticks(1);
        for (int code = int'(OP_CLEAR) + 1; code < NUM_OP_CODES; code++) begin
            add_cmd(3'(code), 8'($urandom));
        end
        add_cmd(OP_LOAD, 8'd255);
        add_ticks(1);
        add_cmd(OP_LOAD, 8'd65);
        add_cmd(OP_LOAD, 8'd64);
        add_ticks(3);
        add_cmd(OP_START, 8'($urandom));
        add_cmd(OP_START, 8'($urandom));
        add_ticks(2);
        add_cmd(OP_STOP, 8'($urandom));
        add_cmd(OP_STOP, 8'($urandom));
        add_ticks(1);
        add_cmd(OP_LOAD, 8'd9);
        add_ticks(2);
        add_cmd(OP_LOAD, 8'd10);
        add_ticks(2);
        add_cmd(OP_CLEAR, 8'($urandom));
        add_ticks(1);

        // Random: mostly load/start/tick sequences, some noise
        live_count = 0;
        while (live_count < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 9) < 8) begin
                roll = $urandom_range(0, 99);
                if (roll < 40)      secs = 8'($urandom_range(1, 2));
                else if (roll < 55) secs = 8'd0;
                else if (roll < 70) secs = 8'($urandom_range(9, 11));
                else if (roll < 90) secs = 8'($urandom_range(12, 64));
                else                secs = 8'($urandom_range(65, 255));
                add_cmd(OP_LOAD, secs);
                if ($urandom_range(0, 3) != 0) add_cmd(OP_START, 8'($urandom));
                repeat ($urandom_range(1, 30)) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 85)      add_ticks(1);
                    else if (roll < 90) add_cmd(OP_STOP, 8'($urandom));
                    else if (roll < 95) add_cmd(OP_START, 8'($urandom));
                    else if (roll < 98) add_cmd(OP_CLEAR, 8'($urandom));
                    else                add_cmd(OP_LOAD, 8'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    add_cmd(3'($urandom_range(0, NUM_OP_CODES - 1)), 8'($urandom));
                end
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every request sent and every result back
        while (pending_cmds.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
